// ===== src/sns_pkg.sv =====
// ============================================================================
// sns_pkg
// Shared types and constants for the sorted note set: command and result
// payloads, mode codes, the cell-to-cell link and the report bus.
// ============================================================================
package sns_pkg;

    // Operation codes carried in cmd.mode
    localparam logic [2:0] MODE_ADD      = 3'd0;
    localparam logic [2:0] MODE_RELEASE  = 3'd1;
    localparam logic [2:0] MODE_CONTAINS = 3'd2;
    localparam logic [2:0] MODE_CLEAR    = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;

    // Lowest / highest note when the list is empty
    localparam logic signed [7:0] NOTE_NONE = -8'sd1;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } state_t;

    // One command transfer
    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [3:0] index;
    } cmd_t;

    // One result transfer
    typedef struct packed {
        logic              accepted;
        logic              entry_valid;
        logic [6:0]        entry_note;
        logic [6:0]        entry_velocity;
        logic [4:0]        note_total;
        logic signed [7:0] lowest_note;
        logic signed [7:0] highest_note;
    } result_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic       add_en;
        logic       rel_en;
        logic [6:0] note;
        logic [6:0] velocity;
    } cell_ctl_t;

    // What a cell shows its neighbors and the controller
    typedef struct packed {
        logic       occ;
        logic       gt;
        logic       eq;
        logic [6:0] note;
        logic [6:0] velocity;
    } cell_link_t;

    // Masked read-out of a cell, OR-combined across the row
    typedef struct packed {
        logic       hit;
        logic [6:0] rd_note;
        logic [6:0] rd_velocity;
        logic       last;
        logic [6:0] last_note;
    } cell_rpt_t;

    // Boundary links at the ends of the row
    localparam cell_link_t LINK_HEAD = '{occ: 1'b1, gt: 1'b0, eq: 1'b0,
                                         note: 7'd0, velocity: 7'd0};
    localparam cell_link_t LINK_TAIL = '{occ: 1'b0, gt: 1'b0, eq: 1'b0,
                                         note: 7'd0, velocity: 7'd0};

endpackage

// ===== src/sns_cell.sv =====
// ============================================================================
// sns_cell
// One slot of the sorted list. Holds a note and velocity, compares against
// the broadcast note and shifts toward or away from its neighbors.
// ============================================================================
module sns_cell import sns_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic [CNT_W-1:0] count,
    input  logic [3:0]       rd_index,
    input  cell_ctl_t        ctl,
    input  cell_link_t       left,
    input  cell_link_t       right,
    output cell_link_t       link,
    output cell_rpt_t        rpt
);

    logic [6:0] note_reg, note_next;
    logic [6:0] vel_reg,  vel_next;
    logic       occ, gt, eq;
    logic       load, take_left, take_right, hit;

    // Occupancy follows from the count; compare with the broadcast note
    assign occ = (32'(count) > IDX);
    assign gt  = occ && (note_reg > ctl.note);
    assign eq  = occ && (note_reg == ctl.note);

    assign link = '{occ: occ, gt: gt, eq: eq, note: note_reg, velocity: vel_reg};

    // Insert point: left neighbor is held and below, this slot is free or above
    assign load       = ctl.add_en && left.occ && !left.gt && (!occ || gt);
    assign take_left  = ctl.add_en && left.gt;
    assign take_right = ctl.rel_en && right.gt;

    always_comb
    begin
        note_next = note_reg;
        vel_next  = vel_reg;
        priority if (take_left)
        begin
            note_next = left.note;
            vel_next  = left.velocity;
        end
        else if (load)
        begin
            note_next = ctl.note;
            vel_next  = ctl.velocity;
        end
        else if (take_right)
        begin
            note_next = right.note;
            vel_next  = right.velocity;
        end
        else
        begin
            note_next = note_reg;
            vel_next  = vel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        vel_reg  <= vel_next;
    end

    // Read-out taps: entry taps zero unless selected, last-note tap only on the last held slot
    assign hit = occ && (32'(rd_index) == IDX);
    assign rpt = '{hit:         hit,
                   rd_note:     hit ? note_reg : 7'd0,
                   rd_velocity: hit ? vel_reg  : 7'd0,
                   last:        occ && !right.occ,
                   last_note:   (occ && !right.occ) ? note_reg : 7'd0};

endmodule

// ===== src/sorted_note_set.sv =====
// ============================================================================
// sorted_note_set
// Held notes of a chord kept sorted by ascending note number in a row of
// compare-and-shift cells; add, release, contains, clear and read by index.
// ============================================================================
//
//  channel   signals              direction  transfer when
//  command   start, busy, cmd     in         start high, busy low at clk rise
//  result    done, result         out        done high (one cycle, no stall)
//
//  The command transfer updates every cell in parallel at that clock edge.
//  The next cycle (busy high) gathers count, lowest, highest and the read
//  entry from the row; done pulses the cycle after, and a new command may
//  be given while done is high.
//  Reset empties the list (count to zero); slot contents are left as is.
//  The receiver cannot stall: done pulses for one cycle; result is held.
//
module sorted_note_set import sns_pkg::*; #(
    parameter int MAX_NOTES = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       mode_reg;
    logic             acc_reg, acc_next;
    logic [3:0]       idx_reg;
    logic             done_reg;
    result_t          result_reg, result_next;

    cell_ctl_t        ctl;
    cell_link_t       links [MAX_NOTES];
    cell_rpt_t        rpts  [MAX_NOTES];
    logic [MAX_NOTES-1:0] eq_vec;
    logic             accept, found, full;
    cell_rpt_t        rpt_or;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_NOTES; g++)
    begin : g_cell
        cell_link_t left_l, right_l;
        if (g == 0)
        begin : g_head
            assign left_l = LINK_HEAD;
        end
        else
        begin : g_mid_l
            assign left_l = links[g-1];
        end
        if (g == MAX_NOTES - 1)
        begin : g_tail
            assign right_l = LINK_TAIL;
        end
        else
        begin : g_mid_r
            assign right_l = links[g+1];
        end

        sns_cell #(.IDX(g), .CNT_W(CNT_W)) u_cell (
            .clk      (clk),
            .count    (count_reg),
            .rd_index (idx_reg),
            .ctl      (ctl),
            .left     (left_l),
            .right    (right_l),
            .link     (links[g]),
            .rpt      (rpts[g])
        );
        assign eq_vec[g] = links[g].eq;
    end

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    assign accept = start && (state_reg == ST_IDLE);
    assign found  = |eq_vec;
    assign full   = (count_reg == CNT_W'(MAX_NOTES));

    assign ctl = '{add_en:   accept && (cmd.mode == MODE_ADD) && !full && !found,
                   rel_en:   accept && (cmd.mode == MODE_RELEASE) && found,
                   note:     cmd.note,
                   velocity: cmd.velocity};

    always_comb
    begin
        count_next = count_reg;
        acc_next   = acc_reg;
        if (accept)
        begin
            acc_next = 1'b0;
            unique case (cmd.mode)
                MODE_ADD:
                begin
                    if (!full && !found)
                    begin
                        count_next = count_reg + 1'b1;
                        acc_next   = 1'b1;
                    end
                end
                MODE_RELEASE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - 1'b1;
                        acc_next   = 1'b1;
                    end
                end
                MODE_CONTAINS: acc_next = found;
                MODE_CLEAR:    count_next = '0;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            acc_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            done_reg  <= (state_reg == ST_REPORT);
        end
    end

    // Command fields kept for the report cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= cmd.mode;
            idx_reg  <= cmd.index;
        end
    end

    // ------------------------------------------------------------------
    // Report: OR the masked cell taps, then register the result
    // ------------------------------------------------------------------
    always_comb
    begin
        rpt_or = '0;
        for (int i = 0; i < MAX_NOTES; i++)
        begin
            rpt_or = rpt_or | rpts[i];
        end
    end

    always_comb
    begin
        result_next                = '0;
        result_next.accepted       = acc_reg;
        result_next.note_total     = 5'(count_reg);
        if (mode_reg == MODE_READ)
        begin
            result_next.entry_valid    = rpt_or.hit;
            result_next.entry_note     = rpt_or.rd_note;
            result_next.entry_velocity = rpt_or.rd_velocity;
        end
        if (count_reg != '0)
        begin
            result_next.lowest_note  = {1'b0, links[0].note};
            result_next.highest_note = {1'b0, rpt_or.last_note};
        end
        else
        begin
            result_next.lowest_note  = NOTE_NONE;
            result_next.highest_note = NOTE_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REPORT)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_REPORT))
        else $error("done without a report cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NOTES))
        else $error("note count above capacity");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && mode_reg == MODE_ADD && acc_reg)
        |-> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("accepted add did not grow the list");

    a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((count_reg == '0) == (result_reg.lowest_note == NOTE_NONE)))
        else $error("empty marker disagrees with count");

endmodule
